// ===== rtl/mlfq_pkg.sv =====
// Package for the multilevel feedback scheduler.
// Holds sizes, field widths, the sequencer state type and the channel payload types.
package mlfq_pkg;
    localparam int TASKS  = 16;
    localparam int LEVELS = 5;
    localparam int TW     = $clog2(TASKS);
    localparam int LW     = 3;
    localparam int FIFO_DEPTH = LEVELS * TASKS;
    localparam int FAW    = $clog2(FIFO_DEPTH);

    localparam logic OP_ARRIVE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    typedef struct packed {
        logic          op;
        logic [3:0]    task_req;
        logic [15:0]   service;
    } t_in;

    typedef struct packed {
        logic          ran_valid;
        logic [3:0]    ran_task;
        logic [2:0]    ran_level;
        logic [15:0]   waiting_mask;
        logic          finished;
        logic [31:0]   finish_time;
        logic [31:0]   turnaround;
        logic [31:0]   wait_total;
    } t_out;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_REQ    = 6'b000010,
        S_PICK   = 6'b000100,
        S_RDSLOT = 6'b001000,
        S_RUN    = 6'b010000,
        S_OUT    = 6'b100000
    } t_state;

    // FIFO memory address of entry idx of level lvl.
    function automatic logic [FAW-1:0] fifo_addr(input logic [LW-1:0] lvl,
                                                 input logic [TW-1:0] idx);
        return FAW'(lvl) * FAW'(TASKS) + FAW'(idx);
    endfunction
endpackage

// ===== rtl/mlfq_if.sv =====
// Valid/ready channel interface for the scheduler.
// Payload type is supplied as a parameter; depends on nothing else.
interface mlfq_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/multilevel_feedback_scheduler_top.sv =====
// Top level of the multilevel feedback scheduler.
// Uses mlfq_pkg, mlfq_if and mlfq_ram.
//
// Usage: items arrive on i_in (op, task_req, service). An arrival passes
// through an accept step and an update step and gives no beat. A tick
// passes through accept, a requeue step, a level pick, a FIFO and slot table
// read (registered RAM ports), the charge step and a closing step. Its beat
// is registered on o_out when the charge step completes.
// The block accepts one item at a time; its rate is set by the sequencer
// walking through the single FIFO memory and slot table ports.
// The output register holds a beat until it is taken. New items are still
// accepted while it waits, and the next tick waits at its charge step for
// as many cycles as the receiver stalls.
// i_cfg writes quantum_mode (reset 1) and is always ready.
// Synchronous active-low reset empties all levels, clears the live bits,
// time and the runner. FIFO and slot tables need no clearing.
module multilevel_feedback_scheduler_top (
    input  logic i_clk,
    input  logic i_rst_n,
    mlfq_if.sink   i_in,
    mlfq_if.source o_out,
    mlfq_if.sink   i_cfg
);
    import mlfq_pkg::*;

    t_state r_state;
    t_in    r_item;
    logic   r_qmode;
    logic [31:0] r_now;
    logic [TW-1:0] r_head [LEVELS];
    logic [TW:0]   r_cnt  [LEVELS];
    logic [TASKS-1:0] r_live;
    logic r_active, r_reqp;
    logic [TW-1:0] r_rtask;
    logic [LW-1:0] r_rlevel;
    logic [15:0]   r_left;
    logic          r_picked;
    logic          r_ov;
    t_out          r_out;

    // FIFO memory
    logic f_we;
    logic [FAW-1:0] f_waddr, f_raddr;
    logic [TW-1:0] f_wdata, f_rdata;
    mlfq_ram #(.WIDTH(TW), .DEPTH(FIFO_DEPTH)) u_fifo (
        .i_clk, .i_we(f_we), .i_waddr(f_waddr), .i_wdata(f_wdata),
        .i_raddr(f_raddr), .o_rdata(f_rdata));

    // Slot table: remaining, demand, arrival.
    logic s_we;
    logic [TW-1:0] s_waddr, s_raddr;
    logic [63:0] s_wdata, s_rdata;
    mlfq_ram #(.WIDTH(64), .DEPTH(TASKS)) u_slot (
        .i_clk, .i_we(s_we), .i_waddr(s_waddr), .i_wdata(s_wdata),
        .i_raddr(s_raddr), .o_rdata(s_rdata));

    logic accept_in;
    logic out_fire;
    assign i_in.ready  = r_state == S_IDLE;
    assign accept_in   = i_in.valid && i_in.ready;
    assign out_fire    = r_state == S_RUN && (!r_ov || o_out.ready);
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = r_ov;
    assign o_out.data  = r_out;

    // Requeue destination and pick level.
    logic lower_nonempty;
    logic [LW-1:0] dest;
    logic any_ne;
    logic [LW-1:0] first_ne;
    always_comb begin
        lower_nonempty = 1'b0;
        any_ne = 1'b0;
        first_ne = '0;
        for (int i = 0; i < LEVELS; i++) begin
            if (LW'(i) >= r_rlevel && r_cnt[i] != '0) begin
                lower_nonempty = 1'b1;
            end
        end
        for (int i = LEVELS - 1; i >= 0; i--) begin
            if (r_cnt[i] != '0) begin
                any_ne = 1'b1;
                first_ne = LW'(i);
            end
        end
        dest = r_rlevel;
        if (lower_nonempty && 32'(r_rlevel) + 1 < LEVELS) begin
            dest = r_rlevel + LW'(1);
        end
    end

    logic [TW:0] tail_sum;
    logic [LW-1:0] push_lvl;
    logic [TW-1:0] push_task;
    logic do_push;
    always_comb begin
        push_lvl  = '0;
        push_task = r_item.task_req[TW-1:0];
        do_push   = 1'b0;
        if (r_state == S_REQ && r_item.op == OP_ARRIVE) begin
            do_push = !r_live[r_item.task_req[TW-1:0]] && r_item.service != '0;
        end else if (r_state == S_REQ && r_reqp) begin
            push_lvl = dest;
            push_task = r_rtask;
            do_push = r_cnt[dest] != (TW+1)'(TASKS);
        end
        tail_sum = (TW+1)'(r_head[push_lvl]) + r_cnt[push_lvl];
        f_we    = do_push;
        f_waddr = fifo_addr(push_lvl, tail_sum[TW-1:0]);
        f_wdata = push_task;
        f_raddr = fifo_addr(first_ne, r_head[first_ne]);
        s_we    = r_state == S_REQ && r_item.op == OP_ARRIVE && do_push;
        s_waddr = r_item.task_req[TW-1:0];
        s_wdata = {r_item.service, r_item.service, r_now};
        if (r_state == S_RUN) begin
            s_we    = out_fire && r_active;
            s_waddr = r_rtask;
            s_wdata = {s_rdata[63:48] - 16'd1, s_rdata[47:0]};
        end
        s_raddr = (r_state == S_RDSLOT && r_picked) ? f_rdata : r_rtask;
    end

    logic [15:0] quant;
    logic [15:0] rem_m1;
    logic [31:0] now_p1, turn;
    logic [TASKS-1:0] mask;
    assign quant  = r_qmode ? (16'd1 << r_rlevel) : 16'd1;
    assign rem_m1 = s_rdata[63:48] - 16'd1;
    assign now_p1 = r_now + 32'd1;
    assign turn   = now_p1 - s_rdata[31:0];
    always_comb begin
        mask = r_live;
        if (r_active) begin
            mask[r_rtask] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_qmode <= 1'b1;
            r_now <= '0;
            r_live <= '0;
            r_active <= 1'b0;
            r_reqp <= 1'b0;
            r_ov <= 1'b0;
            r_picked <= 1'b0;
            r_rtask <= '0;
            r_rlevel <= '0;
            for (int i = 0; i < LEVELS; i++) begin
                r_head[i] <= '0;
                r_cnt[i] <= '0;
            end
        end else begin
            if (i_cfg.valid) begin
                r_qmode <= i_cfg.data;
            end
            if (out_fire) begin
                r_ov <= 1'b1;
            end else if (o_out.valid && o_out.ready) begin
                r_ov <= 1'b0;
            end
            if (do_push) begin
                r_cnt[push_lvl] <= r_cnt[push_lvl] + (TW+1)'(1);
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept_in) begin
                        r_item <= i_in.data;
                        r_state <= S_REQ;
                    end
                end
                S_REQ: begin
                    if (r_item.op == OP_ARRIVE) begin
                        if (do_push) begin
                            r_live[r_item.task_req[TW-1:0]] <= 1'b1;
                        end
                        r_state <= S_IDLE;
                    end else begin
                        r_reqp <= 1'b0;
                        r_state <= S_PICK;
                    end
                end
                S_PICK: begin
                    r_picked <= !r_active && any_ne;
                    if (!r_active && any_ne) begin
                        r_head[first_ne] <= r_head[first_ne] + TW'(1);
                        r_cnt[first_ne] <= r_cnt[first_ne] - (TW+1)'(1);
                        r_rlevel <= first_ne;
                        r_active <= 1'b1;
                        r_state <= S_RDSLOT;
                    end else begin
                        r_state <= S_RDSLOT;
                    end
                end
                S_RDSLOT: begin
                    if (r_picked) begin
                        r_rtask <= f_rdata;
                    end
                    r_state <= S_RUN;
                end
                S_RUN: begin
                    if (out_fire) begin
                        r_now <= now_p1;
                        r_out.ran_valid <= r_active;
                        r_out.ran_task <= r_active ? 4'(r_rtask) : 4'd0;
                        r_out.ran_level <= r_active ? 3'(r_rlevel) : 3'd0;
                        r_out.waiting_mask <= 16'(mask);
                        r_out.finish_time <= now_p1;
                        r_out.finished <= 1'b0;
                        r_out.turnaround <= '0;
                        r_out.wait_total <= '0;
                        if (r_active) begin
                            if (rem_m1 == '0) begin
                                r_out.finished <= 1'b1;
                                r_out.turnaround <= turn;
                                r_out.wait_total <= turn - 32'(s_rdata[47:32]);
                                r_live[r_rtask] <= 1'b0;
                                r_active <= 1'b0;
                            end else if ((r_picked ? ((quant > s_rdata[63:48]) ?
                                         s_rdata[63:48] : quant) : r_left) == 16'd1) begin
                                r_active <= 1'b0;
                                r_reqp <= 1'b1;
                            end
                            r_left <= (r_picked ? ((quant > s_rdata[63:48]) ?
                                      s_rdata[63:48] : quant) : r_left) - 16'd1;
                        end
                        r_state <= S_OUT;
                    end
                end
                S_OUT: r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> r_state == S_IDLE) else $error("ready outside idle");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_RUN && r_ov && !o_out.ready |=> r_state == S_RUN)
        else $error("output overwritten");
    a_fin_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_OUT && r_out.finished |-> !r_live[r_out.ran_task[TW-1:0]])
        else $error("finished task still live");
endmodule

// ===== rtl/mlfq_ram.sv =====
// Generic single-port-write, single-read RAM with registered read.
// Depends on nothing.
module mlfq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
